/* rtl/ilm_pkg.sv */
// ----------------------------------------------------------------------------
// ilm_pkg
// Shared widths, codes, queue entry type and helpers for the I/Q level meter.
// ----------------------------------------------------------------------------
package ilm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int LEVEL_W     = 32;
    localparam int SUM_W       = 48;
    localparam int COUNT_W     = 32;
    localparam int DECAY_W     = 16;
    localparam int ABS_SHIFT   = 31 - SAMPLE_BITS;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int SQ_FRAC     = 2 * SAMPLE_BITS - 2;
    localparam int LEVEL_FRAC  = 30;
    localparam int PROD_W      = LEVEL_W + DECAY_W + 3;

    localparam logic [DECAY_W:0]   DECAY_ONE   = {1'b1, {DECAY_W{1'b0}}};
    localparam logic [DECAY_W-1:0] DECAY_RESET = {1'b1, {(DECAY_W-1){1'b0}}};

    // level reduction codes
    localparam logic [1:0] MODE_ABS_I   = 2'd0;
    localparam logic [1:0] MODE_ABS_Q   = 2'd1;
    localparam logic [1:0] MODE_MAX_ABS = 2'd2;
    localparam logic [1:0] MODE_MAG_SQ  = 2'd3;

    // request kinds
    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // register map (index = paddr[2])
    localparam int   APB_ADDR_W = 3;
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_DECAY  = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic               action;
        logic [LEVEL_W-1:0] level;
    } ilm_entry_t;

    function automatic logic [SAMPLE_BITS-1:0] sample_mag(
        input logic [SAMPLE_BITS-1:0] x
    );
        logic [SAMPLE_BITS-1:0] neg;
        neg = ~x + {{(SAMPLE_BITS-1){1'b0}}, 1'b1};
        return x[SAMPLE_BITS-1] ? neg : x;
    endfunction

endpackage

/* rtl/ilm_front.sv */
// ----------------------------------------------------------------------------
// ilm_front
// Accepts requests, reduces the I/Q sample to a Q2.30 level and registers the
// classified entry ahead of the queue.
// ----------------------------------------------------------------------------
module ilm_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic                                action,
    input  logic signed [ilm_pkg::SAMPLE_BITS-1:0] in_phase,
    input  logic signed [ilm_pkg::SAMPLE_BITS-1:0] quadrature,
    input  logic [1:0]                          reduce_mode,
    input  logic                                queue_full,
    output logic                                push,
    output ilm_pkg::ilm_entry_t                 push_entry
);
    import ilm_pkg::*;

    logic                   front_valid_reg;
    logic                   front_valid_next;
    ilm_entry_t             front_entry_reg;
    logic                   advance;
    logic                   accept;
    logic [SAMPLE_BITS-1:0] mag_i;
    logic [SAMPLE_BITS-1:0] mag_q;
    logic [LEVEL_W-1:0]     abs_i_lvl;
    logic [LEVEL_W-1:0]     abs_q_lvl;
    logic [SQ_W-1:0]        sq_sum;
    logic [LEVEL_W-1:0]     sq_lvl;
    logic [LEVEL_W-1:0]     level;

    assign mag_i     = sample_mag(in_phase);
    assign mag_q     = sample_mag(quadrature);
    assign abs_i_lvl = LEVEL_W'(mag_i) << ABS_SHIFT;
    assign abs_q_lvl = LEVEL_W'(mag_q) << ABS_SHIFT;
    assign sq_sum    = SQ_W'(mag_i) * SQ_W'(mag_i) + SQ_W'(mag_q) * SQ_W'(mag_q);

    generate
        if (SQ_FRAC >= LEVEL_FRAC)
        begin : g_sq_down
            assign sq_lvl = LEVEL_W'(sq_sum >> (SQ_FRAC - LEVEL_FRAC));
        end
        else
        begin : g_sq_up
            assign sq_lvl = LEVEL_W'(sq_sum) << (LEVEL_FRAC - SQ_FRAC);
        end
    endgenerate

    always_comb
    begin
        case (reduce_mode)
            MODE_ABS_I:   level = abs_i_lvl;
            MODE_ABS_Q:   level = abs_q_lvl;
            MODE_MAX_ABS: level = (abs_i_lvl > abs_q_lvl) ? abs_i_lvl : abs_q_lvl;
            default:      level = sq_lvl;
        endcase
    end

    // the stage takes a new request, or empties, whenever the queue takes its entry
    assign push         = front_valid_reg && !queue_full;
    assign advance      = !front_valid_reg || !queue_full;
    assign sample_stall = !advance;
    assign accept       = sample_valid && advance;
    assign push_entry   = front_entry_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (advance)
        begin
            front_valid_next = accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_entry_reg.action <= action;
            front_entry_reg.level  <= level;
        end
    end

endmodule

/* rtl/ilm_queue.sv */
// ----------------------------------------------------------------------------
// ilm_queue
// Short FIFO of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module ilm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ilm_pkg::ilm_entry_t push_entry,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output ilm_pkg::ilm_entry_t head
);
    import ilm_pkg::*;

    ilm_entry_t        slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/ilm_back.sv */
// ----------------------------------------------------------------------------
// ilm_back
// Applies queued entries to the statistics and holds the result register.
// ----------------------------------------------------------------------------
module ilm_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  ilm_pkg::ilm_entry_t           head,
    output logic                          pop,
    input  logic [ilm_pkg::DECAY_W-1:0]   decay_factor,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [ilm_pkg::COUNT_W-1:0]   count_out,
    output logic [ilm_pkg::LEVEL_W-1:0]   peak_out,
    output logic [ilm_pkg::SUM_W-1:0]     sum_out,
    output logic [ilm_pkg::LEVEL_W-1:0]   average_out
);
    import ilm_pkg::*;

    logic [LEVEL_W-1:0]        peak_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [LEVEL_W-1:0]        avg_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      result_valid_reg;
    logic                      result_valid_next;
    logic [COUNT_W-1:0]        count_out_reg;
    logic [LEVEL_W-1:0]        peak_out_reg;
    logic [SUM_W-1:0]          sum_out_reg;
    logic [LEVEL_W-1:0]        average_out_reg;
    logic                      out_free;
    logic                      do_accum;
    logic                      do_read;
    logic [LEVEL_W-1:0]        lvl;
    logic [SUM_W:0]            sum_wide;
    logic signed [LEVEL_W:0]   diff;
    logic [DECAY_W:0]          weight;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  step;
    logic [LEVEL_W-1:0]        avg_next;

    assign lvl      = head.level;
    assign out_free = !result_valid_reg || !result_stall;
    assign pop      = head_valid && ((head.action == ACT_ACCUM) || out_free);
    assign do_accum = pop && (head.action == ACT_ACCUM);
    assign do_read  = pop && (head.action == ACT_READ);

    assign sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(lvl);

    // avg + ((lvl - avg) * (1 - d)) >> 16, identical to the weighted form
    assign diff     = $signed({1'b0, lvl}) - $signed({1'b0, avg_reg});
    assign weight   = DECAY_ONE - {1'b0, decay_factor};
    assign prod     = diff * $signed({1'b0, weight});
    assign step     = prod >>> DECAY_W;
    assign avg_next = avg_reg + LEVEL_W'(step);

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (do_read)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg         <= '0;
            sum_reg          <= '0;
            avg_reg          <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (do_read)
            begin
                peak_reg  <= '0;
                sum_reg   <= '0;
                avg_reg   <= '0;
                count_reg <= '0;
            end
            else if (do_accum)
            begin
                if (lvl > peak_reg)
                begin
                    peak_reg <= lvl;
                end
                // saturate at full scale
                sum_reg <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
                avg_reg <= avg_next;
                if (count_reg != {COUNT_W{1'b1}})
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_read)
        begin
            count_out_reg   <= count_reg;
            peak_out_reg    <= peak_reg;
            sum_out_reg     <= sum_reg;
            average_out_reg <= avg_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign count_out    = count_out_reg;
    assign peak_out     = peak_out_reg;
    assign sum_out      = sum_out_reg;
    assign average_out  = average_out_reg;

endmodule

/* rtl/iq_level_meter.sv */
// ----------------------------------------------------------------------------
// iq_level_meter
// Reduces I/Q samples to levels and keeps peak, sum, decayed average and
// count; a read request returns them and clears them.
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  sample    sample_valid / sample_stall  action, in_phase, quadrature
//  result    result_valid / result_stall  count_out, peak_out, sum_out,
//                                         average_out
//  config    APB psel/penable/pwrite      paddr, pwdata, prdata
//
//  One request per cycle is sustained unless a read waits on a stalled result.
//  A request waits with its level in the level register, then in the queue,
//  then updates the statistics; a read loads the result register as it clears
//  them. The average update is one 33x18 multiply and add per cycle.
//  A stalled result holds a read at the head of the queue; four more requests
//  wait in the queue and the level register before sample_stall rises.
//  Reset clears all statistics and loads the register defaults.
// ----------------------------------------------------------------------------
module iq_level_meter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    output logic                                   sample_stall,
    input  logic                                   action,
    input  logic signed [ilm_pkg::SAMPLE_BITS-1:0] in_phase,
    input  logic signed [ilm_pkg::SAMPLE_BITS-1:0] quadrature,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output logic [ilm_pkg::COUNT_W-1:0]            count_out,
    output logic [ilm_pkg::LEVEL_W-1:0]            peak_out,
    output logic [ilm_pkg::SUM_W-1:0]              sum_out,
    output logic [ilm_pkg::LEVEL_W-1:0]            average_out,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ilm_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);
    import ilm_pkg::*;

    logic [1:0]         reduce_mode_reg;
    logic [DECAY_W-1:0] decay_factor_reg;
    logic               reg_wr;
    logic               reg_sel;
    logic               q_full;
    logic               q_empty;
    logic               q_push;
    logic               q_pop;
    ilm_entry_t         q_in;
    ilm_entry_t         q_head;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign reg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (reg_sel)
            REG_MODE: prdata = {30'd0, reduce_mode_reg};
            default:  prdata = {{(32-DECAY_W){1'b0}}, decay_factor_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reduce_mode_reg  <= MODE_MAG_SQ;
            decay_factor_reg <= DECAY_RESET;
        end
        else if (reg_wr)
        begin
            case (reg_sel)
                REG_MODE: reduce_mode_reg  <= pwdata[1:0];
                default:  decay_factor_reg <= pwdata[DECAY_W-1:0];
            endcase
        end
    end

    ilm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .action       (action),
        .in_phase     (in_phase),
        .quadrature   (quadrature),
        .reduce_mode  (reduce_mode_reg),
        .queue_full   (q_full),
        .push         (q_push),
        .push_entry   (q_in)
    );

    ilm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    ilm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (!q_empty),
        .head         (q_head),
        .pop          (q_pop),
        .decay_factor (decay_factor_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .count_out    (count_out),
        .peak_out     (peak_out),
        .sum_out      (sum_out),
        .average_out  (average_out)
    );

endmodule

/* rtl/ilm_checker.sv */
// ----------------------------------------------------------------------------
// ilm_checker
// Port-level checks for the I/Q level meter, bound to the top level.
// ----------------------------------------------------------------------------
module ilm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [ilm_pkg::COUNT_W-1:0]   count_out,
    input logic [ilm_pkg::LEVEL_W-1:0]   peak_out,
    input logic [ilm_pkg::SUM_W-1:0]     sum_out,
    input logic [ilm_pkg::LEVEL_W-1:0]   average_out
);
    import ilm_pkg::*;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = {1'b1, {(LEVEL_W-1){1'b0}}};

    // hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(count_out)
            && $stable(peak_out) && $stable(sum_out) && $stable(average_out))
        else $error("stalled result changed");

    // no samples since the last read means every statistic is cleared
    a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (count_out == '0) |->
            (peak_out == '0) && (sum_out == '0) && (average_out == '0))
        else $error("statistics nonzero with zero count");

    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (peak_out <= LEVEL_MAX) && (SUM_W'(peak_out) <= sum_out))
        else $error("peak out of range or above sum");

    a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (average_out <= LEVEL_MAX))
        else $error("average above full scale");

endmodule

bind iq_level_meter ilm_checker u_ilm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .count_out    (count_out),
    .peak_out     (peak_out),
    .sum_out      (sum_out),
    .average_out  (average_out)
);
